### hw/rtl/dsa_pkg.sv
`timescale 1ns / 1ps

package dsa_pkg;

  localparam int WORD_BITS = 32;
  localparam int FULL_BITS = 3 * WORD_BITS;
  localparam int SCALE_BITS = 8;
  localparam int MANTISSA_BITS_DEF = 96;

  // Bits of the dividend consumed per cycle by the divide-by-ten unit.
  localparam int CHUNK_BITS = 8;

  localparam logic [SCALE_BITS-1:0] SCALE_LIMIT = 8'd28;
  localparam logic [SCALE_BITS-1:0] RESTORE_MIN = 8'd3;
  localparam logic [4:0] DIGIT_BASE = 5'd10;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_POS_OVF = 2'd1;
  localparam logic [1:0] ST_NEG_OVF = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_WAIT,
    S_FINISH
  } state_t;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } op_t;

  typedef struct packed {
    logic      start;
    op_t       op;
  } unit_ctl_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } unit_sts_t;

  typedef struct packed {
    logic [WORD_BITS-1:0]  a_word0;
    logic [WORD_BITS-1:0]  a_word1;
    logic [WORD_BITS-1:0]  a_word2;
    logic [SCALE_BITS-1:0] a_scale;
    logic                  a_negative;
    logic [WORD_BITS-1:0]  b_word0;
    logic [WORD_BITS-1:0]  b_word1;
    logic [WORD_BITS-1:0]  b_word2;
    logic [SCALE_BITS-1:0] b_scale;
    logic                  b_negative;
  } in_t;

  typedef struct packed {
    logic [WORD_BITS-1:0]  ra_word0;
    logic [WORD_BITS-1:0]  ra_word1;
    logic [WORD_BITS-1:0]  ra_word2;
    logic [SCALE_BITS-1:0] ra_scale;
    logic                  ra_negative;
    logic [WORD_BITS-1:0]  rb_word0;
    logic [WORD_BITS-1:0]  rb_word1;
    logic [WORD_BITS-1:0]  rb_word2;
    logic [SCALE_BITS-1:0] rb_scale;
    logic                  rb_negative;
    logic [1:0]            status;
  } out_t;

endpackage

### hw/rtl/dsa_unit.sv
`timescale 1ns / 1ps

// Shared arithmetic unit: times ten registered on start, divide by ten one
// chunk of dividend bits per cycle.
module dsa_unit #(
  parameter int MANTISSA_BITS = dsa_pkg::MANTISSA_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  dsa_pkg::unit_ctl_t       ctl,
  input  logic [MANTISSA_BITS-1:0] operand,
  output dsa_pkg::unit_sts_t       sts,
  output logic [MANTISSA_BITS-1:0] result
);

  localparam int ChunkBits = dsa_pkg::CHUNK_BITS;
  localparam int PadBits = ((MANTISSA_BITS + ChunkBits - 1) / ChunkBits) * ChunkBits;
  localparam int Chunks = PadBits / ChunkBits;
  localparam int CntW = $clog2(Chunks + 1);

  logic [PadBits-1:0]       acc;
  logic [3:0]               rem;
  logic [3:0]               rem_next;
  logic [ChunkBits-1:0]     qbyte;
  logic [CntW-1:0]          cnt;
  logic                     busy;
  logic                     done;
  logic                     ovf;
  logic [MANTISSA_BITS+3:0] wide;
  logic [MANTISSA_BITS+3:0] prod;

  // Ten times x is eight times x plus two times x.
  assign wide = {4'b0000, operand};
  assign prod = (wide << 3) + (wide << 1);

  // Restoring division by ten over one chunk, most significant bit first.
  always_comb begin
    logic [4:0] part;
    logic [3:0] r;
    logic [ChunkBits-1:0] top;
    top = acc[PadBits-1 -: ChunkBits];
    r = rem;
    qbyte = '0;
    for (int i = 0; i < ChunkBits; i++) begin
      part = {r, top[ChunkBits-1-i]};
      if (part >= dsa_pkg::DIGIT_BASE) begin
        qbyte[ChunkBits-1-i] = 1'b1;
        part = part - dsa_pkg::DIGIT_BASE;
      end
      r = part[3:0];
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        if (ctl.op == dsa_pkg::OP_MUL) begin
          acc  <= PadBits'(prod[MANTISSA_BITS-1:0]);
          ovf  <= |prod[MANTISSA_BITS+3:MANTISSA_BITS];
          done <= 1'b1;
        end else begin
          acc  <= PadBits'(operand);
          rem  <= 4'd0;
          ovf  <= 1'b0;
          cnt  <= CntW'(Chunks);
          busy <= 1'b1;
        end
      end else if (busy) begin
        acc <= {acc[PadBits-ChunkBits-1:0], qbyte};
        rem <= rem_next;
        cnt <= cnt - CntW'(1);
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign result   = acc[MANTISSA_BITS-1:0];
  assign sts.done = done;
  assign sts.ovf  = ovf;

endmodule

### hw/rtl/decimal_scale_align.sv
`timescale 1ns / 1ps

// Channel    Direction  Handshake                      Payload
// operands   in         operand_valid / operand_stall  dsa_pkg::in_t, two decimals
// result     out        result_valid / result_stall    dsa_pkg::out_t, aligned pair
//
// A request runs as a series of times-ten and divide-by-ten steps on the shared unit,
// whose divide retires 8 dividend bits per cycle; an unrecovered overflow goes
// straight to the result without a further decide pass.
// Reset is synchronous and active high; it clears the sequencer and the result valid.
// operand_stall is high from acceptance until the result is moved into the output
// register; a stalled result waits there while the next request is taken.
module decimal_scale_align #(
  parameter int MANTISSA_BITS = dsa_pkg::MANTISSA_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          operand_valid,
  output logic          operand_stall,
  input  dsa_pkg::in_t  operands,
  output logic          result_valid,
  input  logic          result_stall,
  output dsa_pkg::out_t result
);

  localparam int SB = dsa_pkg::SCALE_BITS;
  localparam int WB = dsa_pkg::WORD_BITS;
  localparam int FB = dsa_pkg::FULL_BITS;

  dsa_pkg::state_t state, state_next;

  // Working copies of both operands.
  logic [MANTISSA_BITS-1:0] a_man, a_man_next, b_man, b_man_next;
  logic [SB-1:0]            a_sc, a_sc_next, b_sc, b_sc_next;
  logic                     a_neg, a_neg_next, b_neg, b_neg_next;
  logic [1:0]               err, err_next;

  // Set once an overflow has been undone; from then on only the larger
  // scale is divided down until the scales meet.
  logic fix, fix_next;

  // Operand and operation of the step in flight.
  logic        sel_b, sel_b_next;
  dsa_pkg::op_t op, op_next;

  logic                 result_valid_next;
  dsa_pkg::out_t        result_next;
  logic                 load_result;

  dsa_pkg::unit_ctl_t       ctl;
  dsa_pkg::unit_sts_t       sts;
  logic [MANTISSA_BITS-1:0] unit_in;
  logic [MANTISSA_BITS-1:0] unit_out;

  logic [FB-1:0] a_full_in, b_full_in, a_ext, b_ext;
  logic [SB-1:0] sel_sc, other_sc, sel_sc_up;
  logic          sel_neg;

  dsa_unit #(
    .MANTISSA_BITS(MANTISSA_BITS)
  ) u_unit (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .operand(unit_in),
    .sts    (sts),
    .result (unit_out)
  );

  // Input bits at and above the mantissa width are dropped.
  assign a_full_in = {operands.a_word2, operands.a_word1, operands.a_word0};
  assign b_full_in = {operands.b_word2, operands.b_word1, operands.b_word0};
  assign a_ext     = FB'(a_man);
  assign b_ext     = FB'(b_man);

  assign sel_sc    = sel_b ? b_sc : a_sc;
  assign other_sc  = sel_b ? a_sc : b_sc;
  assign sel_neg   = sel_b ? b_neg : a_neg;
  assign sel_sc_up = SB'(sel_sc + SB'(1));

  assign unit_in       = sel_b_next ? b_man : a_man;
  assign operand_stall = (state != dsa_pkg::S_IDLE);
  assign load_result   = (state == dsa_pkg::S_FINISH) && (!result_valid || !result_stall);

  always_comb begin
    result_next.ra_word0    = a_ext[WB-1:0];
    result_next.ra_word1    = a_ext[2*WB-1:WB];
    result_next.ra_word2    = a_ext[3*WB-1:2*WB];
    result_next.ra_scale    = a_sc;
    result_next.ra_negative = a_neg;
    result_next.rb_word0    = b_ext[WB-1:0];
    result_next.rb_word1    = b_ext[2*WB-1:WB];
    result_next.rb_word2    = b_ext[3*WB-1:2*WB];
    result_next.rb_scale    = b_sc;
    result_next.rb_negative = b_neg;
    result_next.status      = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= dsa_pkg::S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    a_man <= a_man_next;
    b_man <= b_man_next;
    a_sc  <= a_sc_next;
    b_sc  <= b_sc_next;
    a_neg <= a_neg_next;
    b_neg <= b_neg_next;
    err   <= err_next;
    fix   <= fix_next;
    sel_b <= sel_b_next;
    op    <= op_next;
    if (load_result) begin
      result <= result_next;
    end
  end

  // Sequencer: pick a step, run it on the shared unit, commit, repeat.
  always_comb begin
    state_next = state;
    a_man_next = a_man;
    b_man_next = b_man;
    a_sc_next  = a_sc;
    b_sc_next  = b_sc;
    a_neg_next = a_neg;
    b_neg_next = b_neg;
    err_next   = err;
    fix_next   = fix;
    sel_b_next = sel_b;
    op_next    = op;
    ctl.start  = 1'b0;
    ctl.op     = op;
    result_valid_next = result_valid && result_stall;

    case (state)
      dsa_pkg::S_IDLE: begin
        if (operand_valid) begin
          a_man_next = a_full_in[MANTISSA_BITS-1:0];
          b_man_next = b_full_in[MANTISSA_BITS-1:0];
          a_sc_next  = operands.a_scale;
          b_sc_next  = operands.b_scale;
          a_neg_next = operands.a_negative;
          b_neg_next = operands.b_negative;
          err_next   = dsa_pkg::ST_OK;
          fix_next   = 1'b0;
          state_next = dsa_pkg::S_DECIDE;
        end
      end

      dsa_pkg::S_DECIDE: begin
        if (a_sc == b_sc) begin
          state_next = dsa_pkg::S_FINISH;
        end else if (fix) begin
          sel_b_next = (a_sc < b_sc);
          op_next    = dsa_pkg::OP_DIV;
          state_next = dsa_pkg::S_WAIT;
        end else if ((a_sc > b_sc) && (b_sc < dsa_pkg::SCALE_LIMIT)) begin
          sel_b_next = 1'b1;
          op_next    = dsa_pkg::OP_MUL;
          state_next = dsa_pkg::S_WAIT;
        end else if ((a_sc < b_sc) && (a_sc < dsa_pkg::SCALE_LIMIT)) begin
          sel_b_next = 1'b0;
          op_next    = dsa_pkg::OP_MUL;
          state_next = dsa_pkg::S_WAIT;
        end else if (b_sc > dsa_pkg::SCALE_LIMIT) begin
          sel_b_next = 1'b1;
          op_next    = dsa_pkg::OP_DIV;
          state_next = dsa_pkg::S_WAIT;
        end else if (a_sc > dsa_pkg::SCALE_LIMIT) begin
          sel_b_next = 1'b0;
          op_next    = dsa_pkg::OP_DIV;
          state_next = dsa_pkg::S_WAIT;
        end else begin
          state_next = dsa_pkg::S_FINISH;
        end
        ctl.start = (state_next == dsa_pkg::S_WAIT);
        ctl.op    = op_next;
      end

      dsa_pkg::S_WAIT: begin
        if (sts.done) begin
          state_next = dsa_pkg::S_DECIDE;
          if (op == dsa_pkg::OP_MUL && sts.ovf &&
              sel_sc_up > dsa_pkg::RESTORE_MIN && other_sc > dsa_pkg::RESTORE_MIN) begin
            // Overflow with both scales still large: the failing step is
            // dropped and the larger scale is divided down instead.
            fix_next = 1'b1;
          end else begin
            if (sel_b) begin
              b_man_next = unit_out;
              b_sc_next  = (op == dsa_pkg::OP_MUL) ? sel_sc_up : SB'(b_sc - SB'(1));
            end else begin
              a_man_next = unit_out;
              a_sc_next  = (op == dsa_pkg::OP_MUL) ? sel_sc_up : SB'(a_sc - SB'(1));
            end
            if (op == dsa_pkg::OP_MUL && sts.ovf) begin
              err_next   = sel_neg ? dsa_pkg::ST_NEG_OVF : dsa_pkg::ST_POS_OVF;
              state_next = dsa_pkg::S_FINISH;
            end
          end
        end
      end

      dsa_pkg::S_FINISH: begin
        if (load_result) begin
          result_valid_next = 1'b1;
          state_next        = dsa_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = dsa_pkg::S_IDLE;
      end
    endcase
  end

  // A clean result always has matching scales.
  a_ok_scales_match: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == dsa_pkg::ST_OK) |-> result.ra_scale == result.rb_scale)
    else $error("status ok with unequal scales");

  // An overflow is only reported when one scale is too small to restore.
  a_ovf_small_scale: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status != dsa_pkg::ST_OK) |->
      (result.ra_scale <= dsa_pkg::RESTORE_MIN) || (result.rb_scale <= dsa_pkg::RESTORE_MIN))
    else $error("overflow reported although both scales allow restore");

  // The shared unit finishes only while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    sts.done |-> state == dsa_pkg::S_WAIT)
    else $error("arithmetic unit finished outside a wait");

  // The status code is never the unused value.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.status != 2'd3)
    else $error("undefined status code");

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for decimal_scale_align.
//
// Every operand request accepted on the input channel is run through a
// behavioral predictor in this file. The predictor brings the two decimals to
// a common scale and pushes the expected aligned pair onto a queue. Each
// result that the block hands over is compared field by field against the
// oldest entry of that queue. Both channels idle in random bursts for most of
// the run, and the last stretch runs back to back with no idling at all.
module tb;

  localparam int WORD_BITS = dsa_pkg::WORD_BITS;
  localparam int FULL_BITS = dsa_pkg::FULL_BITS;
  localparam int SCALE_BITS = dsa_pkg::SCALE_BITS;
  localparam int MANT = dsa_pkg::MANTISSA_BITS_DEF;
  localparam logic [FULL_BITS-1:0] MANT_MASK = {FULL_BITS{1'b1}} >> (FULL_BITS - MANT);
  localparam logic [FULL_BITS-1:0] ALL_ONES = MANT_MASK;
  localparam int MAX_PRINTS = 40;

  logic           clk;
  logic           rst;
  logic           operand_valid;
  logic           operand_stall;
  dsa_pkg::in_t   operands;
  logic           result_valid;
  logic           result_stall;
  dsa_pkg::out_t  result;

  // Expected aligned pairs, oldest first.
  dsa_pkg::out_t  pending_aligned[$];
  dsa_pkg::out_t  want;
  int    mismatches;
  int    results_seen;
  // Set for the last part of the run, where neither side idles.
  bit    quiet_tail;

  decimal_scale_align #(
    .MANTISSA_BITS(MANT)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .operand_valid(operand_valid),
    .operand_stall(operand_stall),
    .operands(operands),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety net: several times the run length even if every request took the
  // longest divide run of the 8-bit scale range under the longest stalls.
  initial begin
    #200_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Ten times the mantissa, cut back to the mantissa width. The top bit of the
  // return value tells whether anything was lost above that width.
  function automatic logic [FULL_BITS:0] times_ten(input logic [FULL_BITS-1:0] m);
    logic [FULL_BITS+3:0] wide;
    wide = m;
    wide = wide * 10;
    return {(wide >> MANT) != 0, wide[FULL_BITS-1:0] & MANT_MASK};
  endfunction

  function automatic dsa_pkg::out_t align_pair(input dsa_pkg::in_t x);
    logic [FULL_BITS-1:0]  am, bm, am_prev, bm_prev;
    logic [SCALE_BITS-1:0] a_sc, b_sc, a_sc_prev, b_sc_prev;
    logic [FULL_BITS:0]    prod;
    logic [1:0]            code;
    dsa_pkg::out_t         r;
    am = {x.a_word2, x.a_word1, x.a_word0} & MANT_MASK;
    bm = {x.b_word2, x.b_word1, x.b_word0} & MANT_MASK;
    a_sc = x.a_scale;
    b_sc = x.b_scale;
    am_prev = am;
    bm_prev = bm;
    a_sc_prev = a_sc;
    b_sc_prev = b_sc;
    code = dsa_pkg::ST_OK;

    // One step per pass. Scaling up the smaller side takes priority over
    // scaling down whichever side sits above the limit.
    while (a_sc != b_sc && code == dsa_pkg::ST_OK) begin
      am_prev = am;
      bm_prev = bm;
      a_sc_prev = a_sc;
      b_sc_prev = b_sc;
      if (a_sc > b_sc && b_sc < dsa_pkg::SCALE_LIMIT) begin
        prod = times_ten(bm);
        bm = prod[FULL_BITS-1:0];
        b_sc = b_sc + 1'b1;
        if (prod[FULL_BITS]) code = x.b_negative ? dsa_pkg::ST_NEG_OVF : dsa_pkg::ST_POS_OVF;
      end else if (a_sc < b_sc && a_sc < dsa_pkg::SCALE_LIMIT) begin
        prod = times_ten(am);
        am = prod[FULL_BITS-1:0];
        a_sc = a_sc + 1'b1;
        if (prod[FULL_BITS]) code = x.a_negative ? dsa_pkg::ST_NEG_OVF : dsa_pkg::ST_POS_OVF;
      end else if (b_sc > dsa_pkg::SCALE_LIMIT) begin
        bm = bm / 10;
        b_sc = b_sc - 1'b1;
      end else if (a_sc > dsa_pkg::SCALE_LIMIT) begin
        am = am / 10;
        a_sc = a_sc - 1'b1;
      end else begin
        break;
      end
    end

    // An overflow with both scales still comfortably above zero is recovered:
    // undo the failing step and bring the finer operand down instead.
    if (code != dsa_pkg::ST_OK && a_sc > dsa_pkg::RESTORE_MIN &&
        b_sc > dsa_pkg::RESTORE_MIN) begin
      am = am_prev;
      bm = bm_prev;
      a_sc = a_sc_prev;
      b_sc = b_sc_prev;
      while (a_sc != b_sc) begin
        if (a_sc < b_sc) begin
          bm = bm / 10;
          b_sc = b_sc - 1'b1;
        end else begin
          am = am / 10;
          a_sc = a_sc - 1'b1;
        end
      end
      code = dsa_pkg::ST_OK;
    end

    r.ra_word0 = am[WORD_BITS-1:0];
    r.ra_word1 = am[2*WORD_BITS-1:WORD_BITS];
    r.ra_word2 = am[3*WORD_BITS-1:2*WORD_BITS];
    r.ra_scale = a_sc;
    r.ra_negative = x.a_negative;
    r.rb_word0 = bm[WORD_BITS-1:0];
    r.rb_word1 = bm[2*WORD_BITS-1:WORD_BITS];
    r.rb_word2 = bm[3*WORD_BITS-1:2*WORD_BITS];
    r.rb_scale = b_sc;
    r.rb_negative = x.b_negative;
    r.status = code;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic dsa_pkg::in_t make_pair(input logic [FULL_BITS-1:0] am,
                                    input logic [SCALE_BITS-1:0] a_sc, input logic a_neg,
                                    input logic [FULL_BITS-1:0] bm,
                                    input logic [SCALE_BITS-1:0] b_sc, input logic b_neg);
    dsa_pkg::in_t x;
    x.a_word0 = am[WORD_BITS-1:0];
    x.a_word1 = am[2*WORD_BITS-1:WORD_BITS];
    x.a_word2 = am[3*WORD_BITS-1:2*WORD_BITS];
    x.a_scale = a_sc;
    x.a_negative = a_neg;
    x.b_word0 = bm[WORD_BITS-1:0];
    x.b_word1 = bm[2*WORD_BITS-1:WORD_BITS];
    x.b_word2 = bm[3*WORD_BITS-1:2*WORD_BITS];
    x.b_scale = b_sc;
    x.b_negative = b_neg;
    return x;
  endfunction

  // Mantissas of several shapes: full width, short, zero and close to the top,
  // so that the times-ten steps overflow often enough.
  function automatic logic [FULL_BITS-1:0] random_mantissa();
    logic [FULL_BITS-1:0] m;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: m = {$urandom, $urandom, $urandom};
      4, 5: m = {64'd0, $urandom};
      6: m = {32'd0, $urandom, $urandom};
      7: m = '0;
      8: m = ALL_ONES - $urandom_range(0, 1000);
      default: m = {$urandom | 32'hF000_0000, $urandom, $urandom};
    endcase
    return m & MANT_MASK;
  endfunction

  // Most scales stay between 0 and 31, no more than 3 above the limit of 28, so that a request finishes quickly.
  // A few go anywhere in the 8-bit range, which costs hundreds of divide steps.
  function automatic logic [SCALE_BITS-1:0] random_scale();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return SCALE_BITS'($urandom_range(0, 31));
    else if (r < 97) return SCALE_BITS'($urandom_range(0, 60));
    else return SCALE_BITS'($urandom_range(0, 255));
  endfunction

  // Offers one request and holds it until the block takes it, then records the
  // expected result. Now and then the sender goes quiet for a burst of cycles.
  task automatic send_pair(input dsa_pkg::in_t x);
    operands <= x;
    operand_valid <= 1'b1;
    @(posedge clk);
    while (operand_stall) @(posedge clk);
    pending_aligned.push_back(align_pair(x));
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      operand_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("[%0t] result %0d: %s", $realtime, results_seen, what);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
    if (got !== exp_val) flag_mismatch($sformatf("%s is %h, expected %h", name, got, exp_val));
  endtask

  // The receiver stalls in random bursts, except in the quiet tail.
  initial begin
    result_stall = 1'b0;
    forever begin
      repeat ($urandom_range(1, 20)) @(posedge clk);
      if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // A result moves at an edge where valid is high and stall is low. Values are
  // read at the edge itself, before any of this edge's updates land.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_aligned.size() == 0) begin
        flag_mismatch("result arrived with no request outstanding");
      end else begin
        want = pending_aligned.pop_front();
        compare_field("ra_word0", result.ra_word0, want.ra_word0);
        compare_field("ra_word1", result.ra_word1, want.ra_word1);
        compare_field("ra_word2", result.ra_word2, want.ra_word2);
        compare_field("ra_scale", result.ra_scale, want.ra_scale);
        compare_field("ra_negative", result.ra_negative, want.ra_negative);
        compare_field("rb_word0", result.rb_word0, want.rb_word0);
        compare_field("rb_word1", result.rb_word1, want.rb_word1);
        compare_field("rb_word2", result.rb_word2, want.rb_word2);
        compare_field("rb_scale", result.rb_scale, want.rb_scale);
        compare_field("rb_negative", result.rb_negative, want.rb_negative);
        compare_field("status", result.status, want.status);
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked corners: equal scales, zero and full-width mantissas, both
  // extremes of the scale range, overflow of either sign with and without
  // recovery, and the boundaries around the limit and the recovery threshold.
  task automatic test_directed_corners();
    logic [FULL_BITS-1:0] pat_a;
    logic [FULL_BITS-1:0] pat_5;
    pat_a = 96'hAAAA_AAAA_AAAA_AAAA_AAAA_AAAA & MANT_MASK;
    pat_5 = 96'h5555_5555_5555_5555_5555_5555 & MANT_MASK;
    // Equal scales pass straight through.
    send_pair(make_pair(ALL_ONES, 8'd0, 1'b1, ALL_ONES, 8'd0, 1'b0));
    send_pair(make_pair('0, 8'd28, 1'b1, '0, 8'd28, 1'b0));
    send_pair(make_pair(ALL_ONES, 8'd255, 1'b0, ALL_ONES, 8'd255, 1'b1));
    // Full climb from scale 0 to the limit without overflow.
    send_pair(make_pair(96'd1, 8'd0, 1'b0, 96'd1, 8'd28, 1'b1));
    // Zero mantissas keep their signs, at opposite ends of the scale range and at its top.
    send_pair(make_pair('0, 8'd255, 1'b1, '0, 8'd0, 1'b0));
    send_pair(make_pair('0, 8'd255, 1'b0, '0, 8'd254, 1'b1));
    // Long divide run on one side and a climb on the other.
    send_pair(make_pair(ALL_ONES, 8'd255, 1'b1, 96'd5, 8'd0, 1'b0));
    // Overflow near scale zero: no recovery, the sign picks the status.
    send_pair(make_pair(ALL_ONES, 8'd0, 1'b0, 96'd1, 8'd5, 1'b0));
    send_pair(make_pair(ALL_ONES, 8'd0, 1'b1, 96'd1, 8'd5, 1'b0));
    send_pair(make_pair(96'd1, 8'd5, 1'b1, ALL_ONES, 8'd2, 1'b1));
    // Overflow with both scales above the threshold is recovered.
    send_pair(make_pair(ALL_ONES, 8'd5, 1'b0, 96'd7, 8'd10, 1'b1));
    send_pair(make_pair(96'd12345, 8'd10, 1'b0, ALL_ONES, 8'd4, 1'b1));
    // Recovery threshold: a failing step landing on scale 4 recovers, on 3 not.
    send_pair(make_pair(ALL_ONES, 8'd3, 1'b0, ALL_ONES, 8'd4, 1'b0));
    send_pair(make_pair(ALL_ONES, 8'd2, 1'b0, ALL_ONES, 8'd4, 1'b0));
    // Climbing the smaller side comes before dividing the side above the limit.
    send_pair(make_pair(ALL_ONES, 8'd29, 1'b0, ALL_ONES, 8'd0, 1'b1));
    send_pair(make_pair(96'd1, 8'd0, 1'b0, ALL_ONES, 8'd29, 1'b0));
    send_pair(make_pair(ALL_ONES >> 4, 8'd3, 1'b0, 96'd1, 8'd40, 1'b0));
    // Both sides at or above the limit only divide; a side just below it climbs instead.
    send_pair(make_pair(pat_a, 8'd40, 1'b1, pat_5, 8'd28, 1'b0));
    send_pair(make_pair(pat_5, 8'd28, 1'b0, pat_a, 8'd200, 1'b1));
    send_pair(make_pair(96'd3, 8'd28, 1'b0, 96'd9, 8'd29, 1'b1));
    send_pair(make_pair(96'd1, 8'd27, 1'b0, '0, 8'd28, 1'b1));
  endtask

  task automatic test_random_alignment(input int count);
    dsa_pkg::in_t x;
    repeat (count) begin
      x = make_pair(random_mantissa(), random_scale(), 1'($urandom_range(0, 1)),
                    random_mantissa(), random_scale(), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 9) == 0) x.b_scale = x.a_scale;
      send_pair(x);
    end
  endtask

  // The same random mix with both sides ready every cycle, so that requests
  // follow each other as fast as the block allows.
  task automatic test_back_to_back(input int count);
    quiet_tail = 1'b1;
    test_random_alignment(count);
  endtask

  initial begin
    rst = 1'b1;
    operand_valid = 1'b0;
    operands = '0;
    mismatches = 0;
    results_seen = 0;
    quiet_tail = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_directed_corners();
    test_random_alignment(740);
    test_back_to_back(60);
    operand_valid <= 1'b0;

    // Drain: every request gives exactly one result, so once the queue is
    // empty only a short settling wait is needed.
    while (pending_aligned.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
